[rtl/core/tco_pkg.sv]
package tco_pkg;

  // Number of colour-bar panes; the table holds one more entry for the bottom colour.
  localparam int MaxPanes  = 16;
  localparam int PaneEntries = MaxPanes + 1;
  localparam int PaneIdxW  = $clog2(PaneEntries);

  localparam int SampleW   = 24;
  localparam int ThrW      = 16;
  localparam int NodeW     = 32;
  localparam int PaneSelW  = 5;
  localparam int BoundW    = 17;
  localparam int RgbW      = 24;
  localparam int CountW    = 32;
  localparam int CutW      = 16;
  localparam int KindW     = 2;
  localparam int PaneCntW  = 5;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 16;
  localparam int OpW       = 2;
  localparam int InDataW   = 120;
  localparam int OutDataW  = 120;

  typedef enum logic [OpW-1:0] {
    OpNode  = 2'd0,
    OpLoad  = 2'd1,
    OpClear = 2'd2
  } op_e;

  typedef enum logic [KindW-1:0] {
    KindS16  = 2'd0,
    KindByte = 2'd1,
    KindRgb  = 2'd2
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgThrEnable = 2'd0,
    CfgThrCut    = 2'd1,
    CfgDataKind  = 2'd2,
    CfgPaneCount = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic load_pane;
    logic clear_cnt;
    logic capture;
    logic emit;
  } dp_cmd_t;

endpackage

[rtl/core/tco_ctrl.sv]
module tco_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [tco_pkg::OpW-1:0] s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output tco_pkg::dp_cmd_t       cmd_o
);
  import tco_pkg::*;

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StEval = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   m_valid_q, m_valid_d;
  logic   accept;
  logic   out_free;

  assign s_axis_tready = (state_q == StIdle);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  always_comb begin
    cmd_o.load_pane = accept && (s_axis_tuser == OpLoad);
    cmd_o.clear_cnt = accept && (s_axis_tuser == OpClear);
    cmd_o.capture   = accept && (s_axis_tuser == OpNode);
    cmd_o.emit      = (state_q == StEval) && out_free;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (cmd_o.capture) state_d = StEval;
      StEval: if (cmd_o.emit) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    if (cmd_o.emit) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end else begin
      m_valid_d = m_valid_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

endmodule

[rtl/core/tco_datapath.sv]
module tco_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tco_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [tco_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic [tco_pkg::InDataW-1:0]     in_data_i,
  input  tco_pkg::dp_cmd_t                cmd_i,
  output logic [tco_pkg::OutDataW-1:0]    out_data_o,
  output logic                            out_colored_o
);
  import tco_pkg::*;

  // Configuration
  logic                thr_en_q;
  logic [CutW-1:0]     thr_cut_q;
  logic [KindW-1:0]    kind_q;
  logic [PaneCntW-1:0] pane_cnt_q;

  // Pane table
  logic signed [BoundW-1:0] bound_q  [PaneEntries];
  logic [RgbW-1:0]          colour_q [PaneEntries];
  logic                     flag_q   [PaneEntries];

  // Request fields
  logic [SampleW-1:0]       in_sample;
  logic [ThrW-1:0]          in_thr;
  logic [NodeW-1:0]         in_node;
  logic                     in_first;
  logic [PaneSelW-1:0]      in_pane_idx;
  logic signed [BoundW-1:0] in_pane_bound;
  logic [RgbW-1:0]          in_pane_rgb;
  logic                     in_pane_col;

  assign in_sample     = in_data_i[23:0];
  assign in_thr        = in_data_i[39:24];
  assign in_node       = in_data_i[71:40];
  assign in_first      = in_data_i[72];
  assign in_pane_idx   = in_data_i[77:73];
  assign in_pane_bound = signed'(in_data_i[94:78]);
  assign in_pane_rgb   = in_data_i[118:95];
  assign in_pane_col   = in_data_i[119];

  // Stage registers between search and table read
  logic [PaneIdxW-1:0] sel_q;
  logic                pass_q;
  logic                rgb_mode_q;
  logic [RgbW-1:0]     sample_q;
  logic [NodeW-1:0]    node_q;
  logic                first_q;

  // Running counters
  logic [CountW-1:0] nodes_q, nodes_d;
  logic [CountW-1:0] voxels_q, voxels_d;

  // Output register
  logic [OutDataW-1:0] out_q;
  logic                out_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_en_q   <= 1'b0;
      thr_cut_q  <= '0;
      kind_q     <= KindS16;
      pane_cnt_q <= PaneCntW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgThrEnable: thr_en_q   <= cfg_data_i[0];
        CfgThrCut:    thr_cut_q  <= cfg_data_i[CutW-1:0];
        CfgDataKind:  kind_q     <= cfg_data_i[KindW-1:0];
        CfgPaneCount: pane_cnt_q <= cfg_data_i[PaneCntW-1:0];
        default: ;
      endcase
    end
  end

  // Drop load requests that point past the bottom entry
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_pane && (int'(in_pane_idx) <= MaxPanes)) begin
      bound_q[PaneIdxW'(in_pane_idx)]  <= in_pane_bound;
      colour_q[PaneIdxW'(in_pane_idx)] <= in_pane_rgb;
      flag_q[PaneIdxW'(in_pane_idx)]   <= in_pane_col;
    end
  end

  // Threshold cut and pane search
  logic signed [ThrW+1:0]   thr_x;
  logic signed [ThrW+1:0]   cut_x;
  logic                     pass;
  logic signed [BoundW-1:0] value;
  logic [PaneIdxW-1:0]      n_panes;
  logic [PaneIdxW-1:0]      sel;

  always_comb begin
    thr_x = signed'({{2{in_thr[ThrW-1]}}, in_thr});
    cut_x = signed'({2'b00, thr_cut_q});
    pass  = 1'b1;
    if (thr_en_q) begin
      if (kind_q == KindByte) begin
        pass = !({8'd0, in_thr[7:0]} < thr_cut_q);
      end else begin
        pass = !((thr_x > -cut_x) && (thr_x < cut_x));
      end
    end

    if (kind_q == KindByte) begin
      value = signed'({{(BoundW-8){1'b0}}, in_sample[7:0]});
    end else begin
      value = signed'({{(BoundW-16){in_sample[15]}}, in_sample[15:0]});
    end

    if (int'(pane_cnt_q) > MaxPanes) begin
      n_panes = PaneIdxW'(MaxPanes);
    end else begin
      n_panes = PaneIdxW'(pane_cnt_q);
    end

    // First pane whose bound the value reaches, else the entry at the active pane count
    sel = n_panes;
    for (int i = MaxPanes - 1; i >= 0; i--) begin
      if ((PaneIdxW'(i) < n_panes) && (value >= bound_q[i])) begin
        sel = PaneIdxW'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sel_q      <= sel;
      pass_q     <= pass;
      rgb_mode_q <= (kind_q == KindRgb);
      sample_q   <= in_sample;
      node_q     <= in_node;
      first_q    <= in_first;
    end
  end

  // Table read, colour and counters
  logic            col;
  logic [RgbW-1:0] rgb;

  always_comb begin
    col = 1'b0;
    rgb = '0;
    if (pass_q) begin
      if (rgb_mode_q) begin
        col = (sample_q != '0);
        rgb = sample_q;
      end else begin
        col = flag_q[sel_q];
        rgb = colour_q[sel_q];
      end
    end
    if (!col) begin
      rgb = '0;
    end

    nodes_d  = nodes_q;
    voxels_d = voxels_q;
    if (col) begin
      if (nodes_q != '1) nodes_d = nodes_q + CountW'(1);
      if (first_q && (voxels_q != '1)) voxels_d = voxels_q + CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nodes_q  <= '0;
      voxels_q <= '0;
    end else if (cmd_i.clear_cnt) begin
      nodes_q  <= '0;
      voxels_q <= '0;
    end else if (cmd_i.emit) begin
      nodes_q  <= nodes_d;
      voxels_q <= voxels_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q     <= {voxels_d, nodes_d, rgb[7:0], rgb[15:8], rgb[23:16], node_q};
      out_col_q <= col;
    end
  end

  assign out_data_o    = out_q;
  assign out_colored_o = out_col_q;

endmodule

[rtl/core/threshold_colormap_overlay.sv]
// Threshold colour-map overlay: each node request carries a voxel's function and
// threshold samples plus a surface node ID, and returns the node colour, a colored
// flag and saturating running counts of coloured nodes and voxels. Pane load and
// counter clear requests return nothing. A node request goes through two steps: the
// threshold cut and the parallel compare against all pane bounds with a priority
// encoder into the stage registers, then the pane table read and counter update.
// The result lands in an output register, so the next request is taken as soon as
// the evaluation cycle has handed off its result; that handoff waits only while an
// earlier result still sits unclaimed in the output register. Configuration writes
// are taken any cycle and must happen while no node request is in flight.
module threshold_colormap_overlay (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tco_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tco_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // sample_value[23:0], thr_sample[39:24], node_id[71:40], first_of_voxel[72],
  // pane_index[77:73], pane_threshold[94:78], pane_rgb[118:95], pane_colored[119]
  input  logic [tco_pkg::InDataW-1:0]   s_axis_tdata,
  // op[1:0]
  input  logic [tco_pkg::OpW-1:0]       s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // out_node_id[31:0], red[39:32], green[47:40], blue[55:48],
  // nodes_total[87:56], voxels_total[119:88]
  output logic [tco_pkg::OutDataW-1:0]  m_axis_tdata,
  // colored
  output logic                          m_axis_tuser
);
  import tco_pkg::*;

  dp_cmd_t cmd;

  tco_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cmd_o         (cmd)
  );

  tco_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_data_i     (s_axis_tdata),
    .cmd_i         (cmd),
    .out_data_o    (m_axis_tdata),
    .out_colored_o (m_axis_tuser)
  );

endmodule

[tb/threshold_colormap_overlay_tb.sv]
`timescale 1ns / 1ps

module threshold_colormap_overlay_tb;
  import tco_pkg::*;

  localparam logic [OpW-1:0]   OpSpare    = 2'd3;
  localparam logic [KindW-1:0] KindSpare  = 2'd3;
  localparam int               HoldCycles = 300;
  localparam int               StallLimit = 3000;
  localparam int               SettleCyc  = 4;
  localparam int               DrainCyc   = 16;
  localparam int               Phases     = 22;
  localparam int               PhaseItems = 36;

  typedef struct packed {
    logic [OpW-1:0]      op;
    logic [SampleW-1:0]  sample;
    logic [ThrW-1:0]     thr;
    logic [NodeW-1:0]    node;
    logic                first;
    logic [PaneSelW-1:0] pidx;
    logic [BoundW-1:0]   pthr;
    logic [RgbW-1:0]     prgb;
    logic                pcol;
  } req_t;

  typedef struct packed {
    logic [NodeW-1:0]  node;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic              colored;
    logic [CountW-1:0] nodes;
    logic [CountW-1:0] voxels;
  } colour_t;

  typedef struct {
    bit                  is_cfg;
    cfg_idx_e            idx;
    logic [CfgDataW-1:0] val;
    req_t                req;
    bit                  typed;
    colour_t             want;
  } step_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [OpW-1:0]      s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;

  // mirror of the pane table, counters and registers
  logic signed [BoundW-1:0] bound_q  [PaneEntries];
  logic [RgbW-1:0]          colour_q [PaneEntries];
  logic                     flag_q   [PaneEntries];
  logic [CountW-1:0]        node_cnt_q  = '0;
  logic [CountW-1:0]        voxel_cnt_q = '0;
  logic                     en_q   = 1'b0;
  logic [CutW-1:0]          cut_q  = '0;
  logic [KindW-1:0]         kind_q = KindS16;
  logic [PaneCntW-1:0]      pcnt_q = 5'd1;

  colour_t due_colours[$];
  step_t   plan[$];
  colour_t got_colour, want_colour;

  int err_cnt, node_req_cnt, cut_cnt, load_cnt, clear_cnt, cfg_cnt, coloured_seen;
  int idle_cycles, hold_req_cnt, burst_left;
  bit no_gaps;

  threshold_colormap_overlay u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    // sample_value, thr_sample, node_id, first_of_voxel, pane_index, pane_threshold,
    // pane_rgb, pane_colored
    .s_axis_tdata  (s_axis_tdata),
    // op
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    // out_node_id, red, green, blue, nodes_total, voxels_total
    .m_axis_tdata  (m_axis_tdata),
    // colored
    .m_axis_tuser  (m_axis_tuser)
  );

  always #2 clk_i = ~clk_i;

  function automatic bit colour_node(input req_t r, output colour_t res);
    int cut, t, v, n, lp;
    bit pass, col;
    logic [RgbW-1:0] rgb;
    pass = 1'b1;
    col  = 1'b0;
    rgb  = '0;
    res  = '0;
    case (r.op)
      OpLoad: begin
        load_cnt++;
        if (r.pidx < PaneEntries) begin
          bound_q[r.pidx]  = $signed(r.pthr);
          colour_q[r.pidx] = r.prgb;
          flag_q[r.pidx]   = r.pcol;
        end
        return 1'b0;
      end
      OpClear: begin
        clear_cnt++;
        node_cnt_q  = '0;
        voxel_cnt_q = '0;
        return 1'b0;
      end
      OpNode: node_req_cnt++;
      default: return 1'b0;
    endcase
    if (en_q) begin
      cut = int'(cut_q);
      if (kind_q == KindByte) begin
        pass = (int'(r.thr[7:0]) >= cut);
      end else begin
        t = int'($signed(r.thr));
        if (t > -cut && t < cut) pass = 1'b0;
      end
    end
    if (!pass) cut_cnt++;
    if (pass) begin
      if (kind_q == KindRgb) begin
        rgb = r.sample;
        col = (rgb != '0);
      end else begin
        n  = (pcnt_q > MaxPanes) ? MaxPanes : int'(pcnt_q);
        v  = (kind_q == KindByte) ? int'(r.sample[7:0]) : int'($signed(r.sample[15:0]));
        lp = 0;
        while (lp < n && v < int'(bound_q[lp])) lp++;
        col = flag_q[lp];
        if (col) rgb = colour_q[lp];
      end
    end
    if (col) begin
      if (node_cnt_q != '1) node_cnt_q++;
      if (r.first && voxel_cnt_q != '1) voxel_cnt_q++;
    end
    res = '{node: r.node, red: rgb[23:16], green: rgb[15:8], blue: rgb[7:0],
            colored: col, nodes: node_cnt_q, voxels: voxel_cnt_q};
    return 1'b1;
  endfunction

  function automatic req_t mk_node(input logic [23:0] s, input logic [15:0] t,
                                   input logic [31:0] id, input logic first);
    req_t r;
    r        = '0;
    r.op     = OpNode;
    r.sample = s;
    r.thr    = t;
    r.node   = id;
    r.first  = first;
    return r;
  endfunction

  function automatic req_t mk_load(input logic [4:0] idx, input int bound,
                                   input logic [23:0] rgb, input logic col);
    req_t r;
    r      = '0;
    r.op   = OpLoad;
    r.pidx = idx;
    r.pthr = 17'(bound);
    r.prgb = rgb;
    r.pcol = col;
    return r;
  endfunction

  function automatic req_t mk_op(input logic [OpW-1:0] op);
    req_t r;
    r    = req_t'({$urandom, $urandom, $urandom, $urandom});
    r.op = op;
    return r;
  endfunction

  function automatic colour_t mk_colour(input logic [31:0] id, input logic [23:0] rgb,
                                        input logic col, input int nodes, input int voxels);
    return '{node: id, red: rgb[23:16], green: rgb[15:8], blue: rgb[7:0],
             colored: col, nodes: nodes, voxels: voxels};
  endfunction

  function automatic void add_cfg(input cfg_idx_e idx, input logic [CfgDataW-1:0] val);
    step_t s;
    s.is_cfg = 1'b1;
    s.idx    = idx;
    s.val    = val;
    plan.push_back(s);
  endfunction

  function automatic void add_req(input req_t r, input bit typed = 1'b0,
                                  input colour_t want = '0);
    step_t s;
    s.is_cfg = 1'b0;
    s.req    = r;
    s.typed  = typed;
    s.want   = want;
    plan.push_back(s);
  endfunction

  // set random bits above the register width now and then; the block drops them
  function automatic logic [15:0] garble(input logic [15:0] v, input int w);
    logic [15:0] hi;
    hi = 16'($urandom);
    if ($urandom_range(0, 3) == 0) v = v | (hi & ~((16'd1 << w) - 16'd1));
    return v;
  endfunction

  function automatic logic [23:0] pick_sample();
    logic [23:0] s;
    int d;
    s = 24'($urandom);
    d = int'($urandom_range(0, 2)) - 1;
    if (kind_q == KindRgb && $urandom_range(0, 7) == 0) s = '0;
    else if ($urandom_range(0, 2) == 0)
      s[15:0] = 16'(int'(bound_q[$urandom_range(0, MaxPanes)]) + d);
    return s;
  endfunction

  function automatic logic [15:0] pick_thr();
    logic [15:0] t;
    int c, d;
    t = 16'($urandom);
    c = int'(cut_q);
    d = int'($urandom_range(0, 2)) - 1;
    if ($urandom_range(0, 1)) c = -c;
    if ($urandom_range(0, 2) == 0) t = 16'(c + d);
    if (kind_q == KindByte && $urandom_range(0, 2) == 0) t[7:0] = 8'(int'(cut_q) + d);
    return t;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    err_cnt++;
    if (err_cnt <= 100)
      $display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
  endtask

  task automatic send_req(input req_t r, input bit typed = 1'b0, input colour_t want = '0);
    colour_t res;
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {r.pcol, r.prgb, r.pthr, r.pidx, r.first, r.node, r.thr, r.sample};
    s_axis_tuser  = r.op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (colour_node(r, res)) due_colours.push_back(typed ? want : res);
  endtask

  task automatic offer(input req_t r);
    int gap;
    if (burst_left == 0) begin
      gap = no_gaps ? 0 : (($urandom_range(0, 9) == 0) ? $urandom_range(10, 24)
                                                         : $urandom_range(1, 6));
      repeat (gap) begin
        @(negedge clk_i);
        s_axis_tvalid = 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    send_req(r);
  endtask

  // drop valid, let all results drain, then give in-flight loads time to land
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (due_colours.size() != 0) @(negedge clk_i);
    repeat (SettleCyc) @(negedge clk_i);
  endtask

  task automatic write_cfg(input cfg_idx_e idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    cfg_cnt++;
    case (idx)
      CfgThrEnable: en_q   = val[0];
      CfgThrCut:    cut_q  = val;
      CfgDataKind:  kind_q = val[KindW-1:0];
      CfgPaneCount: pcnt_q = val[PaneCntW-1:0];
      default: ;
    endcase
  endtask

  // receiver: switch among four stall patterns at random intervals, plus one long hold-off
  initial begin
    int mode, left, hold_left, hold_seen;
    left      = 0;
    hold_left = 0;
    hold_seen = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 80);
      end
      left--;
      if (hold_seen != hold_req_cnt) begin
        hold_seen = hold_req_cnt;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready = 1'b0;
      end else begin
        case (mode)
          0: m_axis_tready = 1'b1;
          1: m_axis_tready = 1'($urandom_range(0, 1));
          2: m_axis_tready = (left % 5) < 2;
          default: m_axis_tready = ($urandom_range(0, 5) == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_colour = '{node: m_axis_tdata[31:0], red: m_axis_tdata[39:32],
                     green: m_axis_tdata[47:40], blue: m_axis_tdata[55:48],
                     colored: m_axis_tuser, nodes: m_axis_tdata[87:56],
                     voxels: m_axis_tdata[119:88]};
      if (got_colour.colored) coloured_seen++;
      if (due_colours.size() == 0) begin
        flag_mismatch("result with nothing pending, node", got_colour.node, '0);
      end else begin
        want_colour = due_colours.pop_front();
        if (got_colour.node !== want_colour.node)
          flag_mismatch("out_node_id", got_colour.node, want_colour.node);
        if (got_colour.red !== want_colour.red)
          flag_mismatch("red", 32'(got_colour.red), 32'(want_colour.red));
        if (got_colour.green !== want_colour.green)
          flag_mismatch("green", 32'(got_colour.green), 32'(want_colour.green));
        if (got_colour.blue !== want_colour.blue)
          flag_mismatch("blue", 32'(got_colour.blue), 32'(want_colour.blue));
        if (got_colour.colored !== want_colour.colored)
          flag_mismatch("colored", 32'(got_colour.colored), 32'(want_colour.colored));
        if (got_colour.nodes !== want_colour.nodes)
          flag_mismatch("nodes_total", got_colour.nodes, want_colour.nodes);
        if (got_colour.voxels !== want_colour.voxels)
          flag_mismatch("voxels_total", got_colour.voxels, want_colour.voxels);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    int ph, items, span, j;
    logic [23:0] smp;
    logic [15:0] thr, cut;
    logic [15:0] pc;
    int bound;

    // load every table entry first so no search ever lands on an unwritten one
    for (int i = 0; i < PaneEntries; i++)
      add_req(mk_load(5'(i), 30000 - 4000 * i, 24'($urandom), (i % 4) != 3));

    add_req(mk_node(24'h007FFF, 16'h0000, 32'h0000_0000, 1'b1));
    add_req(mk_node(24'hFF8000, 16'hFFFF, 32'hFFFF_FFFF, 1'b0));
    add_req(mk_op(OpClear));
    // RGB samples: black stays uncolored
    add_cfg(CfgDataKind, 16'(KindRgb));
    add_req(mk_node(24'h000000, 16'h1234, 32'hFFFF_FFFF, 1'b1), 1'b1,
            mk_colour(32'hFFFF_FFFF, 24'h000000, 1'b0, 0, 0));
    add_req(mk_node(24'hFFFFFF, 16'h1234, 32'h0000_0000, 1'b1), 1'b1,
            mk_colour(32'h0000_0000, 24'hFFFFFF, 1'b1, 1, 1));
    add_req(mk_node(24'h123456, 16'h0000, 32'h5A5A_5A5A, 1'b0), 1'b1,
            mk_colour(32'h5A5A_5A5A, 24'h123456, 1'b1, 2, 1));
    // widest signed cut passes only the most negative threshold
    add_cfg(CfgThrEnable, 16'h0001);
    add_cfg(CfgThrCut, 16'h8000);
    add_req(mk_node(24'hABCDEF, 16'h7FFF, 32'h0000_0011, 1'b1), 1'b1,
            mk_colour(32'h0000_0011, 24'h000000, 1'b0, 2, 1));
    add_req(mk_node(24'h010203, 16'h8000, 32'h0000_0012, 1'b1), 1'b1,
            mk_colour(32'h0000_0012, 24'h010203, 1'b1, 3, 2));
    add_cfg(CfgThrCut, 16'h0000);
    add_req(mk_node(24'hFFFFFF, 16'h0000, 32'h0000_0013, 1'b0), 1'b1,
            mk_colour(32'h0000_0013, 24'hFFFFFF, 1'b1, 4, 2));
    // byte cut at its top: 0xFE drops, 0xFF survives
    add_cfg(CfgDataKind, 16'(KindByte));
    add_cfg(CfgThrCut, 16'h00FF);
    add_req(mk_node(24'hFFFFFF, 16'h00FE, 32'h0000_0014, 1'b1), 1'b1,
            mk_colour(32'h0000_0014, 24'h000000, 1'b0, 4, 2));
    add_req(mk_node(24'hFFFF80, 16'hFFFF, 32'h0000_0015, 1'b1));
    add_cfg(CfgThrEnable, 16'h0000);
    add_cfg(CfgDataKind, 16'(KindSpare));
    add_cfg(CfgPaneCount, 16'h0000);
    add_req(mk_node(24'h008000, 16'h0000, 32'h0000_0016, 1'b1));
    add_cfg(CfgPaneCount, 16'h001F);
    add_req(mk_node(24'hFF8000, 16'h0000, 32'h0000_0017, 1'b1));
    add_req(mk_load(5'd17, 0, 24'h00FF00, 1'b1));
    add_req(mk_load(5'd31, 0, 24'hFF0000, 1'b1));
    add_req(mk_op(OpSpare));
    add_req(mk_node(24'h00FFFF, 16'h0000, 32'h0000_0018, 1'b0));
    add_cfg(CfgPaneCount, 16'd16);
    add_req(mk_load(5'd0, 65535, 24'hFFFFFF, 1'b1));
    add_req(mk_load(5'd16, -65536, 24'h808080, 1'b1));
    add_req(mk_node(24'h007FFF, 16'h0000, 32'h0000_0019, 1'b1));

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_idle();
        write_cfg(plan[i].idx, plan[i].val);
      end else begin
        send_req(plan[i].req, plan[i].typed, plan[i].want);
      end
    end

    for (ph = 0; ph < Phases; ph++) begin
      wait_idle();
      if ($urandom_range(0, 1)) write_cfg(CfgThrEnable, garble(16'($urandom_range(0, 1)), 1));
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 5))
          0:       cut = 16'h0000;
          1:       cut = 16'h8000;
          2:       cut = 16'h7FFF;
          3:       cut = 16'($urandom_range(0, 300));
          default: cut = 16'($urandom_range(0, 32768));
        endcase
        write_cfg(CfgThrCut, cut);
      end
      if ($urandom_range(0, 1)) write_cfg(CfgDataKind, garble(16'($urandom_range(0, 3)), KindW));
      if ($urandom_range(0, 1)) begin
        pc = ($urandom_range(0, 6) == 0) ? 16'($urandom_range(0, 31))
                                          : 16'($urandom_range(1, MaxPanes));
        write_cfg(CfgPaneCount, garble(pc, PaneCntW));
      end
      no_gaps    = ($urandom_range(0, 3) == 0);
      burst_left = 0;
      if (ph == Phases / 3) hold_req_cnt++;
      items = 0;
      while (items < PhaseItems) begin
        case ($urandom_range(0, 19))
          0, 1: begin
            bound = ($urandom_range(0, 1)) ? int'($urandom_range(0, 600)) - 300
                                           : int'($signed(17'($urandom)));
            offer(mk_load(($urandom_range(0, 9) == 0) ? 5'($urandom_range(17, 31))
                                                      : 5'($urandom_range(0, MaxPanes)),
                          bound, 24'($urandom), 1'($urandom_range(0, 3) != 0)));
            items++;
          end
          2: begin
            offer(mk_op(OpClear));
            items++;
          end
          3: offer(mk_op(OpSpare));
          4, 5: begin
            // stray node with fully random content and voxel marking
            offer(mk_node(24'($urandom), 16'($urandom), $urandom, 1'($urandom)));
            items++;
          end
          default: begin
            // one voxel: same samples for all of its nodes, first flag on the first
            smp  = pick_sample();
            thr  = pick_thr();
            span = $urandom_range(1, 4);
            for (j = 0; j < span; j++) offer(mk_node(smp, thr, $urandom, j == 0));
            items += span;
          end
        endcase
      end
    end

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (due_colours.size() != 0) @(negedge clk_i);
    repeat (DrainCyc) @(posedge clk_i);

    $display("Covered %0d node requests (%0d colored, %0d cut by threshold), %0d pane loads,",
             node_req_cnt, coloured_seen, cut_cnt, load_cnt);
    $display("%0d counter clears and %0d register writes, with one %0d-cycle output hold-off.",
             clear_cnt, cfg_cnt, HoldCycles);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
